>>> rtl/core/pcerb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcerb_pkg
// Shared widths, constants and types of the per-channel event rate binner.
// ----------------------------------------------------------------------------
package pcerb_pkg;

   localparam int TIME_WIDTH     = 48;
   localparam int COUNT_WIDTH    = 16;
   localparam int CHANNEL_WIDTH  = 6;
   localparam int INTERVAL_WIDTH = 32;

   localparam int DEF_NUM_CHANNELS = 64;
   localparam int CMD_FIFO_DEPTH   = 4;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   localparam logic [INTERVAL_WIDTH-1:0] BIN_INTERVAL_RESET = 32'd1500000;

   // register index, taken from paddr above the byte offset
   localparam logic [0:0] CSR_IDX_BIN_INTERVAL = 1'b0;

   typedef struct packed {
      logic                     dump;
      logic [TIME_WIDTH-1:0]    bin_start;
      logic                     cnt_en;
      logic [CHANNEL_WIDTH-1:0] channel;
   } cmd_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_DUMP,
      BE_COUNT
   } be_state_type;

endpackage

>>> rtl/core/pcerb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcerb_req_if
// Spike event channel: valid/ready handshake with timestamp and channel.
// ----------------------------------------------------------------------------
interface pcerb_req_if import pcerb_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [TIME_WIDTH-1:0]    spike_time;
   logic [CHANNEL_WIDTH-1:0] channel;

   modport source (output valid, output spike_time, output channel, input ready);
   modport sink   (input valid, input spike_time, input channel, output ready);

endinterface

>>> rtl/core/pcerb_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcerb_rsp_if
// Bin report channel: one beat per channel count of a closed bin.
// ----------------------------------------------------------------------------
interface pcerb_rsp_if import pcerb_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [TIME_WIDTH-1:0]    bin_start;
   logic [CHANNEL_WIDTH-1:0] channel_index;
   logic [COUNT_WIDTH-1:0]   count;
   logic                     last_of_bin;

   modport source (output valid, output bin_start, output channel_index,
                   output count, output last_of_bin, input ready);
   modport sink   (input valid, input bin_start, input channel_index,
                   input count, input last_of_bin, output ready);

endinterface

>>> rtl/core/pcerb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcerb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcerb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/pcerb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcerb_front
// Takes spike events, tracks base time and bin end, and queues count and
// bin report commands for the back end.
// ----------------------------------------------------------------------------
module pcerb_front import pcerb_pkg::*; #(
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [INTERVAL_WIDTH-1:0] bin_interval,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [TIME_WIDTH-1:0]     req_spike_time,
   input  logic [CHANNEL_WIDTH-1:0]  req_channel,
   input  logic                      cmd_full,
   output logic                      cmd_push,
   output cmd_type                   cmd
);

   logic                     stg_valid_ff, stg_valid_in;
   logic [TIME_WIDTH-1:0]    stg_time_ff, stg_time_in;
   logic [CHANNEL_WIDTH-1:0] stg_ch_ff, stg_ch_in;
   logic                     started_ff, started_in;
   logic [TIME_WIDTH-1:0]    base_ff, base_in;
   logic [TIME_WIDTH-1:0]    bin_end_ff, bin_end_in;

   logic                  accept;
   logic [TIME_WIDTH-1:0] interval_ext;
   logic [TIME_WIDTH-1:0] now;
   logic                  dump;
   logic [TIME_WIDTH:0]   end_sum;
   logic [TIME_WIDTH-1:0] bin_end_adv;

   assign cmd_push     = stg_valid_ff && !cmd_full;
   assign req_ready    = !stg_valid_ff || cmd_push;
   assign accept       = req_valid && req_ready;
   assign interval_ext = TIME_WIDTH'(bin_interval);

   // relative time, clamped at zero before the base
   assign now  = (stg_time_ff >= base_ff) ? (stg_time_ff - base_ff) : '0;
   assign dump = now > bin_end_ff;

   assign end_sum     = {1'b0, bin_end_ff} + {1'b0, interval_ext};
   assign bin_end_adv = end_sum[TIME_WIDTH] ? '1 : end_sum[TIME_WIDTH-1:0];

   always_comb begin
      cmd.dump      = dump;
      cmd.bin_start = (bin_end_ff >= interval_ext) ? (bin_end_ff - interval_ext) : '0;
      cmd.cnt_en    = 32'(stg_ch_ff) < NUM_CHANNELS;
      cmd.channel   = stg_ch_ff;
   end

   always_comb begin
      stg_valid_in = stg_valid_ff;
      stg_time_in  = stg_time_ff;
      stg_ch_in    = stg_ch_ff;
      started_in   = started_ff;
      base_in      = base_ff;
      bin_end_in   = bin_end_ff;
      if (cmd_push) begin
         stg_valid_in = 1'b0;
         if (dump) begin
            bin_end_in = bin_end_adv;
         end
      end
      if (accept) begin
         stg_valid_in = 1'b1;
         stg_time_in  = req_spike_time;
         stg_ch_in    = req_channel;
         // first event opens the first bin
         if (!started_ff) begin
            started_in = 1'b1;
            base_in    = req_spike_time;
            bin_end_in = interval_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         base_ff      <= '0;
         bin_end_ff   <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         started_ff   <= started_in;
         base_ff      <= base_in;
         bin_end_ff   <= bin_end_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_time_ff <= stg_time_in;
      stg_ch_ff   <= stg_ch_in;
   end

endmodule

>>> rtl/core/pcerb_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcerb_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pcerb_cmd_fifo import pcerb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type          entry_ff [CMD_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full  = fill_ff == CNT_W'(CMD_FIFO_DEPTH);
   assign empty = fill_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/pcerb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcerb_back
// Executes queued commands: streams bin reports out of the count memory
// and updates per-channel counters by read-modify-write.
// ----------------------------------------------------------------------------
module pcerb_back import pcerb_pkg::*; #(
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_empty,
   input  cmd_type                  cmd_head,
   output logic                     cmd_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [TIME_WIDTH-1:0]    rsp_bin_start,
   output logic [CHANNEL_WIDTH-1:0] rsp_channel_index,
   output logic [COUNT_WIDTH-1:0]   rsp_count,
   output logic                     rsp_last_of_bin
);

   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   be_state_type state_ff, state_in;
   cmd_type      cmd_ff, cmd_in;

   logic [CH_IDX_W-1:0]     idx_ff, idx_in;
   logic [NUM_CHANNELS-1:0] vld_ff, vld_in;
   logic [CH_IDX_W-1:0]     rd_addr_ff;
   logic                    fwd_ff;
   logic [COUNT_WIDTH-1:0]  fwd_data_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TIME_WIDTH-1:0]    rsp_bin_start_ff;
   logic [CHANNEL_WIDTH-1:0] rsp_channel_index_ff;
   logic [COUNT_WIDTH-1:0]   rsp_count_ff;
   logic                     rsp_last_ff;

   logic                   rd_en;
   logic [CH_IDX_W-1:0]    rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic [COUNT_WIDTH-1:0] rd_val;
   logic                   wr_en;
   logic [CH_IDX_W-1:0]    wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   load_ok;
   logic                   load;
   logic                   vld_clr;
   logic                   last_ch;

   pcerb_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_CHANNELS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entries without a valid bit read as zero; same-cycle write is bypassed
   assign rd_val  = fwd_ff ? fwd_data_ff : (vld_ff[rd_addr_ff] ? rd_data : '0);
   assign wr_addr = CH_IDX_W'(cmd_ff.channel);
   assign wr_data = (rd_val == '1) ? rd_val : rd_val + 1'b1;
   assign load_ok = !rsp_valid_ff || rsp_ready;
   assign last_ch = idx_ff == CH_IDX_W'(NUM_CHANNELS - 1);

   // outputs of the state machine
   always_comb begin
      cmd_pop = 1'b0;
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      wr_en   = 1'b0;
      load    = 1'b0;
      vld_clr = 1'b0;
      case (state_ff)
         BE_IDLE, BE_COUNT: begin
            wr_en = state_ff == BE_COUNT;
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_head.dump) begin
                  rd_en   = 1'b1;
                  rd_addr = '0;
               end else if (cmd_head.cnt_en) begin
                  rd_en   = 1'b1;
                  rd_addr = CH_IDX_W'(cmd_head.channel);
               end
            end
         end
         BE_DUMP: begin
            if (load_ok) begin
               load = 1'b1;
               if (last_ch) begin
                  vld_clr = 1'b1;
                  if (cmd_ff.cnt_en) begin
                     rd_en   = 1'b1;
                     rd_addr = CH_IDX_W'(cmd_ff.channel);
                  end
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE, BE_COUNT: begin
            if (cmd_empty) begin
               state_in = BE_IDLE;
            end else if (cmd_head.dump) begin
               state_in = BE_DUMP;
            end else if (cmd_head.cnt_en) begin
               state_in = BE_COUNT;
            end else begin
               state_in = BE_IDLE;
            end
         end
         BE_DUMP: begin
            if (load_ok && last_ch) begin
               state_in = cmd_ff.cnt_en ? BE_COUNT : BE_IDLE;
            end
         end
         default: state_in = BE_IDLE;
      endcase
   end

   always_comb begin
      cmd_in = cmd_pop ? cmd_head : cmd_ff;
      idx_in = idx_ff;
      if (cmd_pop) begin
         idx_in = '0;
      end else if (load && !last_ch) begin
         idx_in = idx_ff + 1'b1;
      end
      vld_in = vld_ff;
      if (vld_clr) begin
         vld_in = '0;
      end else if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rd_en) begin
            fwd_ff <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      if (rd_en) begin
         rd_addr_ff  <= rd_addr;
         fwd_data_ff <= wr_data;
      end
      if (load) begin
         rsp_bin_start_ff     <= cmd_ff.bin_start;
         rsp_channel_index_ff <= CHANNEL_WIDTH'(idx_ff);
         rsp_count_ff         <= rd_val;
         rsp_last_ff          <= last_ch;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_start     = rsp_bin_start_ff;
   assign rsp_channel_index = rsp_channel_index_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_last_of_bin   = rsp_last_ff;

endmodule

>>> rtl/core/per_channel_event_rate_binner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_channel_event_rate_binner_core
// Bins timestamped spike events into per-channel counts over fixed intervals
// and reports all channel counts each time a bin closes.
// ----------------------------------------------------------------------------
// The first event after reset sets the base time; each later event whose
// relative time lies past the current bin end closes the bin, which is
// reported as NUM_CHANNELS beats in channel order (last_of_bin on the final
// one); the bin end moves on by one bin_interval as the bin closes and the
// counters restart after the report. The front end takes one event per cycle
// while its four-entry command queue has room. The back end counts one event
// per cycle through a read-modify-write of the count memory; a bin report
// sends one beat per cycle while the sink is ready. Counters clear through
// per-channel valid bits, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module per_channel_event_rate_binner_core import pcerb_pkg::*; #(
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
   input  logic                      clock,
   input  logic                      reset,
   pcerb_req_if.sink                 req_chan,
   pcerb_rsp_if.source               rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [INTERVAL_WIDTH-1:0] bin_interval_ff, bin_interval_in;
   logic                      csr_wr;
   logic                      csr_hit;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_WIDTH-1:2] == CSR_IDX_BIN_INTERVAL;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? CSR_DATA_WIDTH'(bin_interval_ff) : '0;

   assign bin_interval_in = csr_wr ? INTERVAL_WIDTH'(csr_pwdata) : bin_interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_interval_ff <= BIN_INTERVAL_RESET;
      end else begin
         bin_interval_ff <= bin_interval_in;
      end
   end

   pcerb_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .bin_interval   (bin_interval_ff),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_spike_time (req_chan.spike_time),
      .req_channel    (req_chan.channel),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd            (push_cmd)
   );

   pcerb_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .head     (head_cmd),
      .empty    (cmd_empty)
   );

   pcerb_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_empty         (cmd_empty),
      .cmd_head          (head_cmd),
      .cmd_pop           (cmd_pop),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_bin_start     (rsp_chan.bin_start),
      .rsp_channel_index (rsp_chan.channel_index),
      .rsp_count         (rsp_chan.count),
      .rsp_last_of_bin   (rsp_chan.last_of_bin)
   );

endmodule
